>>> rtl/trr_pkg.sv
// trr_pkg: shared types, codes and constants of the tftp read receiver
// used by trr_core.sv, trr_skid.sv and tftp_read_receiver.sv
package trr_pkg;

    localparam int MAX_BLOCK_DEF = 8192;

    localparam logic [15:0] OP_DATA  = 16'd3;
    localparam logic [15:0] OP_ERROR = 16'd5;
    localparam logic [15:0] OP_OACK  = 16'd6;

    localparam logic [13:0] HDR_LEN  = 14'd4;
    localparam logic [13:0] MIN_SIZE = 14'd512;
    localparam logic [13:0] TOP_SIZE = 14'd8192;

    localparam logic [13:0] BLOCK_SIZE_RST  = 14'd4096;
    localparam logic [7:0]  RETRY_LIMIT_RST = 8'd12;
    localparam logic [8:0]  RETRY_SAT       = 9'h1FF;

    localparam logic CMD_PACKET = 1'b0;

    typedef enum logic [1:0] {
        SEND_NONE   = 2'd0,
        SEND_ACK    = 2'd1,
        SEND_RESEND = 2'd2
    } t_send_kind;

    typedef enum logic [1:0] {
        ST_RUNNING = 2'd0,
        ST_DONE    = 2'd1,
        ST_ERROR   = 2'd2,
        ST_TIMEOUT = 2'd3
    } t_status;

    // configuration register indexes
    typedef enum logic {
        REG_BLOCK_SIZE  = 1'b0,
        REG_RETRY_LIMIT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic        cmd;
        logic [15:0] opcode;
        logic [15:0] block_number;
        logic [13:0] packet_len;
    } t_item;

    typedef struct packed {
        t_send_kind  send_kind;
        logic [15:0] ack_block;
        logic        resend_request;
        logic        deliver_data;
        logic [13:0] data_bytes;
        t_status     status;
    } t_result;

    typedef struct packed {
        logic [13:0] block_size;
        logic [7:0]  retry_limit;
    } t_cfg;

endpackage

>>> rtl/trr_if.sv
// trr_if: valid/ready channel interfaces for packet events and results
// depends on no other file
interface trr_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] opcode;
    logic [15:0] block_number;
    logic [13:0] packet_len;

    modport source (output valid, cmd, opcode, block_number, packet_len, input ready);
    modport sink   (input valid, cmd, opcode, block_number, packet_len, output ready);
endinterface

interface trr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  send_kind;
    logic [15:0] ack_block;
    logic        resend_request;
    logic        deliver_data;
    logic [13:0] data_bytes;
    logic [1:0]  status;

    modport source (output valid, send_kind, ack_block, resend_request, deliver_data,
                    data_bytes, status, input ready);
    modport sink   (input valid, send_kind, ack_block, resend_request, deliver_data,
                    data_bytes, status, output ready);
endinterface

>>> rtl/trr_core.sv
// trr_core: transfer state and per-event decision logic
// depends on trr_pkg
module trr_core #(
    parameter int MAX_BLOCK = trr_pkg::MAX_BLOCK_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  trr_pkg::t_item  i_item,
    input  trr_pkg::t_cfg   i_cfg,
    output trr_pkg::t_result o_result
);

    localparam int LEN_CAP = MAX_BLOCK + 64;

    logic [15:0]      r_expected_block, n_expected_block;
    logic [8:0]       r_retry_count,    n_retry_count;
    logic [13:0]      r_active_size,    n_active_size;
    logic             r_last_is_request, n_last_is_request;
    logic [15:0]      r_last_ack_number, n_last_ack_number;
    trr_pkg::t_status r_final_status,   n_final_status;

    logic [13:0] len_c;
    logic [13:0] size_c;
    logic [8:0]  retry_inc;
    logic [13:0] data_len;
    trr_pkg::t_result resend;

    always_comb begin
        if ({3'b000, i_item.packet_len} > 17'(LEN_CAP)) begin
            len_c = 14'(LEN_CAP);
        end else begin
            len_c = i_item.packet_len;
        end
        if (i_cfg.block_size < trr_pkg::MIN_SIZE) begin
            size_c = trr_pkg::MIN_SIZE;
        end else if (i_cfg.block_size > trr_pkg::TOP_SIZE) begin
            size_c = trr_pkg::TOP_SIZE;
        end else begin
            size_c = i_cfg.block_size;
        end
        retry_inc = (r_retry_count == trr_pkg::RETRY_SAT) ? r_retry_count
                                                           : r_retry_count + 9'd1;
        data_len  = len_c - trr_pkg::HDR_LEN;

        resend                = '0;
        resend.send_kind      = trr_pkg::SEND_RESEND;
        resend.resend_request = r_last_is_request;
        resend.ack_block      = r_last_is_request ? 16'd0 : r_last_ack_number;
        resend.status         = trr_pkg::ST_RUNNING;
    end

    always_comb begin
        n_expected_block  = r_expected_block;
        n_retry_count     = r_retry_count;
        n_active_size     = r_active_size;
        n_last_is_request = r_last_is_request;
        n_last_ack_number = r_last_ack_number;
        n_final_status    = r_final_status;
        o_result          = '0;
        o_result.send_kind = trr_pkg::SEND_NONE;
        o_result.status    = trr_pkg::ST_RUNNING;

        if (r_final_status != trr_pkg::ST_RUNNING) begin
            o_result.status = r_final_status;
        end else if (i_item.cmd != trr_pkg::CMD_PACKET) begin
            n_retry_count = retry_inc;
            if (retry_inc > {1'b0, i_cfg.retry_limit}) begin
                n_final_status  = trr_pkg::ST_TIMEOUT;
                o_result.status = trr_pkg::ST_TIMEOUT;
            end else begin
                o_result = resend;
            end
        end else if (len_c < trr_pkg::HDR_LEN) begin
            // runt packet, dropped
        end else if (i_item.opcode == trr_pkg::OP_ERROR) begin
            n_final_status  = trr_pkg::ST_ERROR;
            o_result.status = trr_pkg::ST_ERROR;
        end else if (i_item.opcode == trr_pkg::OP_OACK) begin
            n_active_size      = size_c;
            n_last_is_request  = 1'b0;
            n_last_ack_number  = 16'd0;
            n_retry_count      = 9'd0;
            o_result.send_kind = trr_pkg::SEND_ACK;
        end else if (i_item.opcode == trr_pkg::OP_DATA) begin
            if (i_item.block_number == r_expected_block) begin
                n_last_is_request       = 1'b0;
                n_last_ack_number       = i_item.block_number;
                n_retry_count           = 9'd0;
                n_expected_block        = r_expected_block + 16'd1;
                o_result.send_kind      = trr_pkg::SEND_ACK;
                o_result.ack_block      = i_item.block_number;
                o_result.deliver_data   = 1'b1;
                o_result.data_bytes     = data_len;
                // short payload closes the transfer
                if (data_len < r_active_size) begin
                    n_final_status  = trr_pkg::ST_DONE;
                    o_result.status = trr_pkg::ST_DONE;
                end
            end else if (i_item.block_number == r_expected_block - 16'd1) begin
                o_result = resend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_block  <= 16'd1;
            r_retry_count     <= 9'd0;
            r_active_size     <= trr_pkg::MIN_SIZE;
            r_last_is_request <= 1'b1;
            r_last_ack_number <= 16'd0;
            r_final_status    <= trr_pkg::ST_RUNNING;
        end else if (i_accept) begin
            r_expected_block  <= n_expected_block;
            r_retry_count     <= n_retry_count;
            r_active_size     <= n_active_size;
            r_last_is_request <= n_last_is_request;
            r_last_ack_number <= n_last_ack_number;
            r_final_status    <= n_final_status;
        end
    end

endmodule

>>> rtl/trr_skid.sv
// trr_skid: result register with one skid entry behind it
// depends on trr_pkg
module trr_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  trr_pkg::t_result i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output trr_pkg::t_result o_data
);

    logic             r_out_valid;
    trr_pkg::t_result r_out;
    logic             r_skid_valid;
    trr_pkg::t_result r_skid;
    logic             drain;
    logic             take;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign drain   = r_out_valid && i_ready;
    assign take    = i_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (drain) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (take) begin
            if (!r_out_valid || drain) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (drain) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (drain) begin
                r_out <= r_skid;
            end
        end else if (take) begin
            if (!r_out_valid || drain) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

endmodule

>>> rtl/tftp_read_receiver.sv
// tftp_read_receiver: top level of the tftp read transfer receiver
// depends on trr_pkg, trr_if, trr_core and trr_skid
//
//   channel   dir  handshake          payload
//   i_pkt     in   valid/ready        cmd, opcode, block_number, packet_len
//   o_res     out  valid/ready        send_kind, ack_block, resend_request,
//                                     deliver_data, data_bytes, status
//   apb       in   psel/penable       block_size @0x0, retry_limit @0x4
//
// one event per cycle while i_pkt.ready is high: state updates at the transfer edge,
// and the result is registered into the output register, or the skid entry if that is full
// a two-entry output buffer keeps i_pkt ready while one result waits
// i_pkt.ready drops only when both output entries are full
// synchronous active-low reset restores transfer state and register defaults
module tftp_read_receiver #(
    parameter int MAX_BLOCK = trr_pkg::MAX_BLOCK_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    trr_in_if.sink      i_pkt,
    trr_out_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    trr_pkg::t_cfg    r_cfg;
    trr_pkg::t_item   item;
    trr_pkg::t_result result;
    trr_pkg::t_result res_q;
    trr_pkg::t_reg_idx reg_idx;
    logic             accept;
    logic             in_ready;
    logic             cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = trr_pkg::t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_size  <= trr_pkg::BLOCK_SIZE_RST;
            r_cfg.retry_limit <= trr_pkg::RETRY_LIMIT_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                trr_pkg::REG_BLOCK_SIZE:  r_cfg.block_size  <= pwdata[13:0];
                trr_pkg::REG_RETRY_LIMIT: r_cfg.retry_limit <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            trr_pkg::REG_BLOCK_SIZE:  prdata = {18'd0, r_cfg.block_size};
            trr_pkg::REG_RETRY_LIMIT: prdata = {24'd0, r_cfg.retry_limit};
            default:                  prdata = 32'd0;
        endcase
    end

    assign item.cmd          = i_pkt.cmd;
    assign item.opcode       = i_pkt.opcode;
    assign item.block_number = i_pkt.block_number;
    assign item.packet_len   = i_pkt.packet_len;
    assign i_pkt.ready       = in_ready;
    assign accept            = i_pkt.valid && in_ready;

    trr_core #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    trr_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pkt.valid),
        .o_ready (in_ready),
        .i_data  (result),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_data  (res_q)
    );

    assign o_res.send_kind      = res_q.send_kind;
    assign o_res.ack_block      = res_q.ack_block;
    assign o_res.resend_request = res_q.resend_request;
    assign o_res.deliver_data   = res_q.deliver_data;
    assign o_res.data_bytes     = res_q.data_bytes;
    assign o_res.status         = res_q.status;

endmodule

>>> bench/tftp_read_receiver_checker.sv
// tftp_read_receiver_checker: watches the packet and reply channels and the apb port,
// predicts every reply of the read transfer and compares it field by field
// depends on trr_pkg and trr_if
module tftp_read_receiver_checker #(
    parameter int MAX_BLOCK = trr_pkg::MAX_BLOCK_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    trr_in_if           i_pkt,
    trr_out_if          i_res,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_cnt,
    output int          o_pending,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import trr_pkg::*;

    // receive buffer size, longer packets are cut to it
    localparam logic [13:0] RX_BUF_LEN = 14'(MAX_BLOCK + 64);

    logic [13:0] cfg_block_size;
    logic [7:0]  cfg_retry_limit;

    logic [15:0] next_block;
    logic [8:0]  retries;
    logic [13:0] active_size;
    logic        last_was_request;
    logic [15:0] last_acked;
    t_status     closing;

    t_result replies_due[$];
    int      fails = 0;
    int      checked = 0;
    int      pending_cnt = 0;

    assign o_fail_cnt = fails;
    assign o_pending  = pending_cnt;
    assign o_checked  = checked;

    function automatic t_result resend_last();
        t_result reply;
        reply                = '0;
        reply.send_kind      = SEND_RESEND;
        reply.status         = ST_RUNNING;
        reply.ack_block      = last_was_request ? 16'd0 : last_acked;
        reply.resend_request = last_was_request;
        return reply;
    endfunction

    // advances the transfer state by one event and returns the reply it causes
    function automatic t_result next_reply(input t_item ev);
        t_result     reply;
        logic [13:0] len;
        logic [13:0] payload;
        reply           = '0;
        reply.send_kind = SEND_NONE;
        reply.status    = ST_RUNNING;
        if (closing != ST_RUNNING) begin
            reply.status = closing;
            return reply;
        end
        if (ev.cmd != 1'(CMD_PACKET)) begin
            if (retries != RETRY_SAT)
                retries = retries + 9'd1;
            if (retries > {1'b0, cfg_retry_limit}) begin
                closing      = ST_TIMEOUT;
                reply.status = ST_TIMEOUT;
                return reply;
            end
            return resend_last();
        end
        len = ({3'b000, ev.packet_len} > 17'(MAX_BLOCK + 64)) ? RX_BUF_LEN : ev.packet_len;
        if (len < HDR_LEN)
            return reply;
        if (ev.opcode == OP_ERROR) begin
            closing      = ST_ERROR;
            reply.status = ST_ERROR;
            return reply;
        end
        if (ev.opcode == OP_OACK) begin
            if (cfg_block_size < MIN_SIZE)
                active_size = MIN_SIZE;
            else if (cfg_block_size > TOP_SIZE)
                active_size = TOP_SIZE;
            else
                active_size = cfg_block_size;
            last_was_request = 1'b0;
            last_acked       = 16'd0;
            retries          = 9'd0;
            reply.send_kind  = SEND_ACK;
            return reply;
        end
        if (ev.opcode == OP_DATA) begin
            if (ev.block_number == next_block) begin
                payload          = len - HDR_LEN;
                last_was_request = 1'b0;
                last_acked       = ev.block_number;
                retries          = 9'd0;
                next_block       = next_block + 16'd1;
                if (payload < active_size) begin
                    closing      = ST_DONE;
                    reply.status = ST_DONE;
                end
                reply.send_kind    = SEND_ACK;
                reply.ack_block    = ev.block_number;
                reply.deliver_data = 1'b1;
                reply.data_bytes   = payload;
                return reply;
            end
            if (ev.block_number == next_block - 16'd1)
                return resend_last();
        end
        return reply;
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] seen);
        if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_item   ev;
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            cfg_block_size   = BLOCK_SIZE_RST;
            cfg_retry_limit  = RETRY_LIMIT_RST;
            next_block       = 16'd1;
            retries          = 9'd0;
            active_size      = MIN_SIZE;
            last_was_request = 1'b1;
            last_acked       = 16'd0;
            closing          = ST_RUNNING;
            replies_due.delete();
        end else begin
            // replies go first: one can never belong to an event taken at the same edge
            if (i_res.valid && i_res.ready) begin
                seen.send_kind      = t_send_kind'(i_res.send_kind);
                seen.ack_block      = i_res.ack_block;
                seen.resend_request = i_res.resend_request;
                seen.deliver_data   = i_res.deliver_data;
                seen.data_bytes     = i_res.data_bytes;
                seen.status         = t_status'(i_res.status);
                if (replies_due.size() == 0) begin
                    $display({"%0t: reply with none outstanding, expected nothing, ",
                              "got kind %0d ack %0d status %0d"},
                             $time, seen.send_kind, seen.ack_block, seen.status);
                    fails++;
                end else begin
                    want = replies_due.pop_front();
                    compare_field("send_kind", 16'(want.send_kind), 16'(seen.send_kind));
                    compare_field("ack_block", want.ack_block, seen.ack_block);
                    compare_field("resend_request", 16'(want.resend_request),
                                  16'(seen.resend_request));
                    compare_field("deliver_data", 16'(want.deliver_data),
                                  16'(seen.deliver_data));
                    compare_field("data_bytes", 16'(want.data_bytes), 16'(seen.data_bytes));
                    compare_field("status", 16'(want.status), 16'(seen.status));
                    checked++;
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[2]))
                    REG_BLOCK_SIZE:  cfg_block_size  = i_pwdata[13:0];
                    REG_RETRY_LIMIT: cfg_retry_limit = i_pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_pkt.valid && i_pkt.ready) begin
                ev.cmd          = i_pkt.cmd;
                ev.opcode       = i_pkt.opcode;
                ev.block_number = i_pkt.block_number;
                ev.packet_len   = i_pkt.packet_len;
                replies_due.push_back(next_reply(ev));
            end
        end
        pending_cnt = replies_due.size();
    end

endmodule

>>> bench/tftp_read_receiver_tb.sv
// tftp_read_receiver_tb: drives packet events, timeouts and register writes into the
// read receiver with bursty input and a stalling reply side, and gives the verdict
// depends on trr_pkg, trr_if, tftp_read_receiver and tftp_read_receiver_checker
module tftp_read_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import trr_pkg::*;

    localparam logic        CMD_TIMEOUT = 1'b1;
    localparam logic [15:0] OP_RRQ      = 16'd1;
    localparam logic [15:0] OP_ACK_PKT  = 16'd4;
    localparam logic [15:0] SHORT_OPS [3] = '{OP_DATA, OP_ERROR, OP_OACK};
    localparam int          RUN_LIMIT   = 400000;
    localparam int          HOLD_CYCLES = 48;
    localparam int          PHASES      = 6;

    typedef enum {CLOSE_BY_ERROR, CLOSE_BY_SHORT_DATA, CLOSE_BY_RETRIES} t_close_how;
    typedef enum {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} t_rx_pace;
    typedef enum {NOISE_SHORT, NOISE_OPCODE, NOISE_BLOCK} t_noise;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_cnt;
    int pending;
    int replies_checked;
    int cycles = 0;

    // generator view of the transfer, used only to keep the sequences well formed
    logic [15:0] gen_blk = 16'd1;
    int          gen_act = 512;
    int          gen_tmo = 0;
    int          gen_lim = 12;
    int          gen_bsz = 4096;

    int          burst_left = 0;
    int          events_sent = 0;
    int          reg_writes = 0;
    logic        hold_req = 1'b0;
    t_close_how  close_how;

    trr_in_if  pkt_ch ();
    trr_out_if res_ch ();

    tftp_read_receiver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (pkt_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tftp_read_receiver_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pkt      (pkt_ch),
        .i_res      (res_ch),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_pready   (pready),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending),
        .o_checked  (replies_checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("run limit of %0d cycles hit with %0d replies outstanding",
                     RUN_LIMIT, pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // reply side: changing stall patterns, plus long hold-offs on request
    initial begin
        t_rx_pace pace;
        int       pace_left;
        int       tick;
        pace = RX_ALWAYS;
        pace_left = 0;
        tick = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (hold_req) begin
                res_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (pace_left == 0) begin
                    pace = t_rx_pace'($urandom_range(0, 3));
                    pace_left = $urandom_range(10, 60);
                end
                pace_left--;
                case (pace)
                    RX_ALWAYS:   res_ch.ready = 1'b1;
                    RX_MOSTLY:   res_ch.ready = ($urandom_range(0, 3) != 0);
                    RX_SPARSE:   res_ch.ready = ($urandom_range(0, 9) < 3);
                    default:     res_ch.ready = (tick % 5 != 0);
                endcase
            end
        end
    end

    function automatic t_item packet_of(input logic [15:0] op, input logic [15:0] blk,
                                        input logic [13:0] len);
        t_item ev;
        ev.cmd          = 1'(CMD_PACKET);
        ev.opcode       = op;
        ev.block_number = blk;
        ev.packet_len   = len;
        return ev;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_event(input t_item ev);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                pkt_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        pkt_ch.valid        = 1'b1;
        pkt_ch.cmd          = ev.cmd;
        pkt_ch.opcode       = ev.opcode;
        pkt_ch.block_number = ev.block_number;
        pkt_ch.packet_len   = ev.packet_len;
        @(posedge i_clk);
        while (!pkt_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
        events_sent++;
    endtask

    task automatic send_data_ok(input logic [13:0] len);
        send_event(packet_of(OP_DATA, gen_blk, len));
        gen_blk = gen_blk + 16'd1;
        gen_tmo = 0;
    endtask

    task automatic send_timeout();
        t_item ev;
        // the other fields ride along and must be ignored
        ev.cmd          = CMD_TIMEOUT;
        ev.opcode       = 16'($urandom);
        ev.block_number = 16'($urandom);
        ev.packet_len   = 14'($urandom);
        send_event(ev);
        gen_tmo++;
    endtask

    task automatic send_oack(input logic [13:0] len);
        send_event(packet_of(OP_OACK, 16'($urandom), len));
        gen_act = (gen_bsz < int'(MIN_SIZE)) ? int'(MIN_SIZE) :
                  (gen_bsz > int'(TOP_SIZE)) ? int'(TOP_SIZE) : gen_bsz;
        gen_tmo = 0;
    endtask

    // events that leave the transfer state alone
    task automatic send_noise();
        logic [15:0] op;
        logic [15:0] blk;
        case (t_noise'($urandom_range(0, 2)))
            NOISE_SHORT: begin
                op  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : SHORT_OPS[$urandom_range(0, 2)];
                blk = $urandom_range(0, 1) ? gen_blk : 16'($urandom);
                send_event(packet_of(op, blk, 14'($urandom_range(0, 3))));
            end
            NOISE_OPCODE: begin
                do op = 16'($urandom);
                while (op == OP_DATA || op == OP_ERROR || op == OP_OACK);
                send_event(packet_of(op, 16'($urandom), 14'($urandom)));
            end
            default: begin
                do blk = 16'($urandom);
                while (blk == gen_blk || blk == gen_blk - 16'd1);
                send_event(packet_of(OP_DATA, blk, 14'($urandom)));
            end
        endcase
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == REG_BLOCK_SIZE)
            gen_bsz = int'(value[13:0]);
        else
            gen_lim = int'(value[7:0]);
        reg_writes++;
    endtask

    task automatic wait_replies_drained();
        pkt_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        // one register stage behind the last transfer
        repeat (4) @(negedge i_clk);
    endtask

    // mostly in-order data with random lengths, the rest duplicates, timeouts, option acks and noise
    task automatic run_phase(input int steps);
        int done_steps;
        int pick;
        done_steps = 0;
        while (done_steps < steps) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if ($urandom_range(0, 7) == 0)
                    send_data_ok(14'($urandom_range(gen_act + 4, 16383)));
                else
                    send_data_ok(14'(gen_act + 4 + $urandom_range(0, 63)));
                done_steps++;
            end else if (pick < 65) begin
                send_event(packet_of(OP_DATA, gen_blk - 16'd1, 14'($urandom_range(4, 16383))));
                done_steps++;
            end else if (pick < 75 && gen_tmo < gen_lim) begin
                send_timeout();
                done_steps++;
            end else if (pick < 80) begin
                send_oack(14'($urandom_range(4, 16383)));
                done_steps++;
            end else begin
                send_noise();
            end
        end
    endtask

    initial begin
        int sent_at_close;
        pkt_ch.valid        = 1'b0;
        pkt_ch.cmd          = 1'b0;
        pkt_ch.opcode       = '0;
        pkt_ch.block_number = '0;
        pkt_ch.packet_len   = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: request resends, ignored packets, first blocks, option ack
        send_timeout();
        send_event(packet_of(OP_DATA, 16'd0, 14'd516));
        send_event(packet_of(OP_DATA, 16'd1, 14'd0));
        send_event(packet_of(OP_ERROR, 16'hFFFF, 14'd3));
        send_event(packet_of(16'd0, 16'd1, 14'd4));
        send_event(packet_of(16'hFFFF, 16'hFFFF, 14'h3FFF));
        send_event(packet_of(OP_RRQ, 16'd1, 14'd20));
        send_event(packet_of(OP_ACK_PKT, 16'd1, 14'd4));
        send_data_ok(14'd516);
        send_event(packet_of(OP_DATA, 16'd1, 14'd516));
        send_timeout();
        send_event(packet_of(OP_DATA, 16'd3, 14'd600));
        send_event(packet_of(OP_DATA, 16'hFFFF, 14'd600));
        send_event(packet_of(OP_DATA, 16'd0, 14'd600));
        send_oack(14'd4);
        send_timeout();
        send_data_ok(14'h3FFF);
        send_data_ok(14'd4100);
        send_event(packet_of(OP_DATA, 16'hAAAA, 14'h2AAA));
        send_event(packet_of(16'h5555, 16'h5555, 14'h1555));

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_replies_drained();
            case (ph)
                0: begin
                    write_reg(REG_BLOCK_SIZE, 32'd512);
                    write_reg(REG_RETRY_LIMIT, 32'd255);
                end
                1: begin
                    write_reg(REG_BLOCK_SIZE, 32'd8192);
                    write_reg(REG_RETRY_LIMIT, 32'd0);
                end
                2: begin
                    write_reg(REG_BLOCK_SIZE, 32'd0);
                    write_reg(REG_RETRY_LIMIT, 32'($urandom_range(1, 20)));
                end
                3: begin
                    write_reg(REG_BLOCK_SIZE, 32'h3FFF);
                    write_reg(REG_RETRY_LIMIT, 32'd3);
                end
                4: begin
                    write_reg(REG_BLOCK_SIZE, 32'($urandom_range(512, 8192)));
                    write_reg(REG_RETRY_LIMIT, 32'($urandom_range(0, 255)));
                end
                default: begin
                    write_reg(REG_BLOCK_SIZE, 32'($urandom_range(0, 16383)));
                    write_reg(REG_RETRY_LIMIT, 32'($urandom_range(0, 40)));
                end
            endcase
            // reply side holds off while events keep coming, so the input stalls
            if (ph % 2 == 0)
                hold_req = 1'b1;
            if ($urandom_range(0, 3) != 0)
                send_oack(14'($urandom_range(4, 16383)));
            run_phase(24);
            if (ph == 3)
                wait_replies_drained();
            run_phase(24);
        end

        close_how = t_close_how'($urandom_range(0, 2));
        case (close_how)
            CLOSE_BY_ERROR:
                send_event(packet_of(OP_ERROR, 16'($urandom), 14'($urandom_range(4, 16383))));
            CLOSE_BY_SHORT_DATA:
                send_data_ok(14'($urandom_range(4, gen_act + 3)));
            default:
                while (gen_tmo <= gen_lim) send_timeout();
        endcase
        sent_at_close = events_sent;

        // everything after the close is ignored
        send_timeout();
        send_event(packet_of(OP_DATA, gen_blk, 14'd600));
        send_event(packet_of(OP_OACK, 16'd0, 14'd4));
        send_event(packet_of(OP_ERROR, 16'd0, 14'd4));
        repeat (4) send_event(packet_of(16'($urandom), 16'($urandom), 14'($urandom)));
        wait_replies_drained();

        $display("%0d events sent over %0d register writes, %0d replies checked",
                 events_sent, reg_writes, replies_checked);
        $display("transfer closed by %s, %0d events offered after the close",
                 close_how.name(), events_sent - sent_at_close);
        if (fail_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
